// ===== rtl/multiplexed_servo_pulse_sequencer_defines.svh =====
// assertion macros shared by the checker
// the enclosing scope provides i_clk and i_rst_n
`ifndef MULTIPLEXED_SERVO_PULSE_SEQUENCER_DEFINES_SVH
`define MULTIPLEXED_SERVO_PULSE_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define MSPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("servo sequencer check failed");

// next-cycle implication
`define MSPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("servo sequencer check failed");

`endif

// ===== rtl/msps_pkg.sv =====
`timescale 1ns / 1ps
package msps_pkg;

    localparam int CHANNELS_DEFAULT = 8;
    localparam int MASK_W           = 8;
    localparam int TICK_W           = 16;
    localparam int SLOT_OUT_W       = 4;
    localparam int CH_IN_W          = 3;
    localparam int CFG_IDX_W        = 2;

    typedef logic [TICK_W-1:0] t_ticks;

    localparam t_ticks EMPTY_SLOT_TICKS = 16'd1000;
    localparam t_ticks MIN_RESET        = 16'd1000;
    localparam t_ticks MAX_RESET        = 16'd2000;
    localparam t_ticks FRAME_RESET      = 16'd20000;

    // item opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WIDTH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME       = 2'd3;

    // sequencer actions for one item
    typedef logic [2:0] t_act;
    localparam t_act ACT_HOLD  = 3'd0;
    localparam t_act ACT_STOP  = 3'd1;
    localparam t_act ACT_START = 3'd2;
    localparam t_act ACT_DEC   = 3'd3;
    localparam t_act ACT_ADV   = 3'd4;

    typedef struct packed {
        logic capture;
        logic write;
        logic load_target;
        logic step;
        t_act act;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic mask_zero;
        logic seq_on;
        logic opcode;
        logic rem_gt1;
        logic out_free;
    } t_status;

    // raise to the minimum, then lower to the maximum
    function automatic t_ticks clamp_width(input t_ticks v, input t_ticks mn,
                                           input t_ticks mx);
        t_ticks t;
        t = (v < mn) ? mn : v;
        return (t > mx) ? mx : t;
    endfunction

endpackage

// ===== rtl/msps_ctrl.sv =====
`timescale 1ns / 1ps
module msps_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  msps_pkg::t_status i_status,
    output msps_pkg::t_cmd   o_cmd,
    output logic             o_in_stall
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WRITE = 2'd1;
    localparam logic [1:0] S_STEP  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]          r_state, n_state;
    msps_pkg::t_act      r_act, n_act;

    always_comb begin
        n_act = r_act;
        if (r_state == S_WRITE) begin
            priority if (i_status.mask_zero) begin
                n_act = msps_pkg::ACT_STOP;
            end else if (!i_status.seq_on) begin
                n_act = msps_pkg::ACT_START;
            end else if (i_status.opcode == msps_pkg::OP_TICK) begin
                n_act = i_status.rem_gt1 ? msps_pkg::ACT_DEC : msps_pkg::ACT_ADV;
            end else begin
                n_act = msps_pkg::ACT_HOLD;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_WRITE;
            S_WRITE: n_state = S_STEP;
            S_STEP:  n_state = S_OUT;
            S_OUT:   if (i_status.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_act   <= msps_pkg::ACT_HOLD;
        end else begin
            r_state <= n_state;
            r_act   <= n_act;
        end
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_cmd.capture     = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.write       = (r_state == S_WRITE);
    assign o_cmd.load_target = (r_state == S_WRITE);
    assign o_cmd.step        = (r_state == S_STEP);
    assign o_cmd.act         = r_act;
    assign o_cmd.load_out    = (r_state == S_OUT) && i_status.out_free;

endmodule

// ===== rtl/msps_dp.sv =====
`timescale 1ns / 1ps
module msps_dp #(
    parameter int CHANNELS = msps_pkg::CHANNELS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  msps_pkg::t_cmd                      i_cmd,
    output msps_pkg::t_status                   o_status,
    input  logic                                i_opcode,
    input  logic [msps_pkg::CH_IN_W-1:0]        i_channel,
    input  logic [msps_pkg::TICK_W-1:0]         i_width_ticks,
    input  logic                                i_cfg_we,
    input  logic [msps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [msps_pkg::TICK_W-1:0]         i_cfg_data,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [msps_pkg::MASK_W-1:0]         o_pulse_lines,
    output logic [msps_pkg::SLOT_OUT_W-1:0]     o_active_slot,
    output logic                                o_running
);

    localparam int SW = $clog2(CHANNELS + 1);
    localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [SW-1:0] DEAD = SW'(CHANNELS);

    // configuration
    logic [msps_pkg::MASK_W-1:0] r_mask;
    msps_pkg::t_ticks            r_min, r_max, r_frame;

    // captured item
    logic                        r_op;
    logic [msps_pkg::CH_IN_W-1:0] r_ch;
    msps_pkg::t_ticks            r_wreq;

    // sequencer state
    msps_pkg::t_ticks            r_pw [CHANNELS];
    logic [SW-1:0]               r_slot, n_slot;
    msps_pkg::t_ticks            r_rem, n_rem;
    msps_pkg::t_ticks            r_dead, n_dead;
    logic                        r_on, n_on;
    logic [SW-1:0]               r_target;

    // result register
    logic                        r_o_valid;
    logic [msps_pkg::MASK_W-1:0] r_o_lines;
    logic [msps_pkg::SLOT_OUT_W-1:0] r_o_slot;
    logic                        r_o_run;

    logic [CHANNELS-1:0]         w_en;
    logic [SW-1:0]               w_first, w_after, w_tgt, w_rd_sel;
    logic [IW-1:0]               w_rd_addr;
    msps_pkg::t_ticks            w_w, w_base;
    logic [msps_pkg::MASK_W-1:0] w_lines;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_min   <= msps_pkg::MIN_RESET;
            r_max   <= msps_pkg::MAX_RESET;
            r_frame <= msps_pkg::FRAME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                msps_pkg::REG_ENABLE_MASK: r_mask  <= i_cfg_data[msps_pkg::MASK_W-1:0];
                msps_pkg::REG_MIN_PULSE:   r_min   <= i_cfg_data;
                msps_pkg::REG_MAX_PULSE:   r_max   <= i_cfg_data;
                msps_pkg::REG_FRAME:       r_frame <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_ch   <= i_channel;
            r_wreq <= i_width_ticks;
        end
    end

    // priority encoders: lowest enabled channel, and lowest one past the slot
    always_comb begin
        w_first = DEAD;
        w_after = DEAD;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            w_en[c] = (c < msps_pkg::MASK_W) && r_mask[3'(c)];
            if (w_en[c]) w_first = SW'(c);
            if (w_en[c] && (SW'(c) > r_slot)) w_after = SW'(c);
        end
    end

    assign w_tgt = (!r_on || (r_slot >= DEAD)) ? w_first : w_after;

    // single read port on the width file
    assign w_rd_sel  = i_cmd.step ? r_target : r_slot;
    assign w_rd_addr = (w_rd_sel < DEAD) ? w_rd_sel[IW-1:0] : '0;
    assign w_w       = msps_pkg::clamp_width(r_pw[w_rd_addr], r_min, r_max);
    assign w_base    = (r_slot >= DEAD) ? r_frame : r_dead;

    always_comb begin
        n_slot = r_slot;
        n_rem  = r_rem;
        n_dead = r_dead;
        n_on   = r_on;
        unique case (i_cmd.act)
            msps_pkg::ACT_STOP: begin
                n_on   = 1'b0;
                n_slot = '0;
                n_rem  = '0;
            end
            msps_pkg::ACT_START: begin
                n_on   = 1'b1;
                n_slot = r_target;
                n_dead = (r_frame > w_w) ? r_frame - w_w : '0;
                n_rem  = (w_w != '0) ? w_w : msps_pkg::EMPTY_SLOT_TICKS;
            end
            msps_pkg::ACT_DEC: begin
                n_rem = r_rem - 1'b1;
            end
            msps_pkg::ACT_ADV: begin
                n_slot = r_target;
                if (r_target < DEAD) begin
                    n_dead = (w_base > w_w) ? w_base - w_w : '0;
                    n_rem  = (w_w != '0) ? w_w : msps_pkg::EMPTY_SLOT_TICKS;
                end else begin
                    n_dead = w_base;
                    n_rem  = (w_base != '0) ? w_base : msps_pkg::EMPTY_SLOT_TICKS;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) r_pw[c] <= '0;
            r_slot <= '0;
            r_rem  <= '0;
            r_dead <= msps_pkg::FRAME_RESET;
            r_on   <= 1'b0;
        end else begin
            if (i_cmd.write && (r_op == msps_pkg::OP_WIDTH) && (int'(r_ch) < CHANNELS)) begin
                r_pw[IW'(r_ch)] <= msps_pkg::clamp_width(r_wreq, r_min, r_max);
            end
            if (i_cmd.step) begin
                r_slot <= n_slot;
                r_rem  <= n_rem;
                r_dead <= n_dead;
                r_on   <= n_on;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_target) r_target <= w_tgt;
    end

    assign w_lines = (r_on && (r_slot < DEAD) && (int'(r_slot) < msps_pkg::MASK_W)
                      && (w_w != '0)) ? (8'd1 << 3'(r_slot)) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_lines <= w_lines;
            r_o_slot  <= r_on ? msps_pkg::SLOT_OUT_W'(r_slot) : '0;
            r_o_run   <= r_on;
        end
    end

    assign o_status.mask_zero = (r_mask == '0);
    assign o_status.seq_on    = r_on;
    assign o_status.opcode    = r_op;
    assign o_status.rem_gt1   = (r_rem > 16'd1);
    assign o_status.out_free  = !r_o_valid || !i_out_stall;

    assign o_out_valid   = r_o_valid;
    assign o_pulse_lines = r_o_lines;
    assign o_active_slot = r_o_slot;
    assign o_running     = r_o_run;

endmodule

// ===== rtl/multiplexed_servo_pulse_sequencer.sv =====
`timescale 1ns / 1ps
// time-multiplexed rc servo pulse sequencer
// input channel (i_in_valid / o_in_stall) carries one item per transfer:
//   opcode 0 is a timer tick, opcode 1 stores a clamped width for a channel
// output channel (o_out_valid / i_out_stall) returns one result per item:
//   the pulse lines, the current slot (8 = dead slot) and the running flag
// config port: i_cfg_we writes i_cfg_data to register i_cfg_index
//   (0 enable mask, 1 min width, 2 max width, 3 frame period); write only
//   while no item is in flight
// an input transfer captures the item, followed by the width write and
//   next-channel search, the slot update and the result load to o_out_valid
// o_in_stall stays high until the current item is done; the controller walks one
//   item at a time through the shared width-file read port
// the result register frees the input side: a new item is taken while the
//   previous result still waits; a stalled receiver holds the pipeline in
//   its result-load step until the output register drains
// reset: widths zero, sequencer stopped, mask empty, limits 1000..2000,
//   frame period 20000, no result pending
module multiplexed_servo_pulse_sequencer #(
    parameter int CHANNELS = msps_pkg::CHANNELS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // item input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_opcode,
    input  logic [msps_pkg::CH_IN_W-1:0]        i_channel,
    input  logic [msps_pkg::TICK_W-1:0]         i_width_ticks,
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [msps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [msps_pkg::TICK_W-1:0]         i_cfg_data,
    // result output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [msps_pkg::MASK_W-1:0]         o_pulse_lines,
    output logic [msps_pkg::SLOT_OUT_W-1:0]     o_active_slot,
    output logic                                o_running
);

    msps_pkg::t_cmd    w_cmd;
    msps_pkg::t_status w_status;

    // sequencing of one item through the datapath
    msps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    // width file, slot counters, priority encoders and result register
    msps_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_opcode      (i_opcode),
        .i_channel     (i_channel),
        .i_width_ticks (i_width_ticks),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_pulse_lines (o_pulse_lines),
        .o_active_slot (o_active_slot),
        .o_running     (o_running)
    );

endmodule

// ===== rtl/msps_chk.sv =====
`timescale 1ns / 1ps
`include "multiplexed_servo_pulse_sequencer_defines.svh"
module msps_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_stall,
    input logic                            o_out_valid,
    input logic                            i_out_stall,
    input logic [msps_pkg::MASK_W-1:0]     o_pulse_lines,
    input logic [msps_pkg::SLOT_OUT_W-1:0] o_active_slot,
    input logic                            o_running
);

    // a stalled result stays put
    `MSPS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_pulse_lines))

    // at most one line high per result
    `MSPS_ASSERT_SAME(a_one_line, o_out_valid, $onehot0(o_pulse_lines))

    // a stopped sequencer reports quiet lines and slot zero
    `MSPS_ASSERT_SAME(a_stopped, o_out_valid && !o_running, (o_pulse_lines == '0) && (o_active_slot == '0))

    // one item in flight: input side busy right after a transfer
    `MSPS_ASSERT_NEXT(a_busy, i_in_valid && !o_in_stall, o_in_stall)

endmodule

bind multiplexed_servo_pulse_sequencer msps_chk u_msps_chk (.*);

// ===== dv/multiplexed_servo_pulse_sequencer_tb.sv =====
`timescale 1ns / 1ps
module multiplexed_servo_pulse_sequencer_tb;

    localparam int         N_CH         = msps_pkg::CHANNELS_DEFAULT;
    localparam logic [3:0] DEAD_SLOT    = 4'd8;
    localparam int         IDLE_SPLIT   = 490;   // items per idling regime
    localparam int         PRESSURE_AT  = 150;   // item count that triggers the long hold
    localparam int         HOLD_CYCLES  = 80;
    localparam int         DRAIN_CYCLES = 8;     // idle wait after the last owed result comes back
    localparam int         PRINT_CAP    = 40;

    // one result of the block
    typedef struct packed {
        logic [msps_pkg::MASK_W-1:0]     lines;
        logic [msps_pkg::SLOT_OUT_W-1:0] slot;
        logic                            run;
    } t_slot_report;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one row of the directed table: an item or a register write
    typedef struct packed {
        t_row_kind                        kind;
        logic                             op;
        logic [msps_pkg::CH_IN_W-1:0]     ch;
        msps_pkg::t_ticks                 val;
        logic [msps_pkg::CFG_IDX_W-1:0]   reg_idx;
        logic                             typed;
        t_slot_report                     want;
    } t_stim_row;

    localparam t_slot_report STOPPED   = '{8'h00, 4'd0, 1'b0};
    localparam t_slot_report NO_REPORT = '0;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_stall;
    logic                            i_opcode;
    logic [msps_pkg::CH_IN_W-1:0]    i_channel;
    logic [msps_pkg::TICK_W-1:0]     i_width_ticks;
    logic                            i_cfg_we;
    logic [msps_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [msps_pkg::TICK_W-1:0]     i_cfg_data;
    logic                            o_out_valid;
    logic                            i_out_stall;
    logic [msps_pkg::MASK_W-1:0]     o_pulse_lines;
    logic [msps_pkg::SLOT_OUT_W-1:0] o_active_slot;
    logic                            o_running;

    multiplexed_servo_pulse_sequencer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_channel     (i_channel),
        .i_width_ticks (i_width_ticks),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_pulse_lines (o_pulse_lines),
        .o_active_slot (o_active_slot),
        .o_running     (o_running)
    );

    // shadow of the sequencer: stored widths, slot walk and dead time
    msps_pkg::t_ticks width_store [N_CH];
    logic [3:0]       cur_slot;
    msps_pkg::t_ticks ticks_left;
    logic [16:0]      dead_left;
    logic             seq_on;

    // shadow of the configuration registers
    logic [msps_pkg::MASK_W-1:0] en_mask;
    msps_pkg::t_ticks            lo_width;
    msps_pkg::t_ticks            hi_width;
    msps_pkg::t_ticks            frame_len;

    // results still owed by the block, oldest first
    t_slot_report slot_reports_q [$];

    int unsigned items_sent;
    int unsigned directed_items;
    int unsigned results_checked;
    int unsigned reg_writes;
    int unsigned fail_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // table rows
    function automatic t_stim_row item_row(input logic op,
                                           input logic [msps_pkg::CH_IN_W-1:0] ch,
                                           input msps_pkg::t_ticks val, input logic typed,
                                           input t_slot_report want);
        t_stim_row r;
        r = '{ROW_ITEM, op, ch, val, msps_pkg::REG_ENABLE_MASK, typed, want};
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [msps_pkg::CFG_IDX_W-1:0] idx,
                                          input msps_pkg::t_ticks val);
        t_stim_row r;
        r = '{ROW_CFG, msps_pkg::OP_TICK, 3'd0, val, idx, 1'b0, NO_REPORT};
        return r;
    endfunction

    // raise to the minimum first, then lower to the maximum (maximum wins)
    function automatic msps_pkg::t_ticks limit_width(input msps_pkg::t_ticks v);
        msps_pkg::t_ticks t;
        t = (v < lo_width) ? lo_width : v;
        return (t > hi_width) ? hi_width : t;
    endfunction

    // lowest enabled channel at or above the start, else the dead slot
    function automatic logic [3:0] next_enabled(input int unsigned from);
        for (int unsigned c = from; c < N_CH; c++) begin
            if (en_mask[c]) begin
                return 4'(c);
            end
        end
        return DEAD_SLOT;
    endfunction

    // entering a channel slot re-clamps its width with the current limits
    task automatic enter_slot(input logic [3:0] s);
        msps_pkg::t_ticks w;
        cur_slot = s;
        if (s < N_CH) begin
            w = limit_width(width_store[s[2:0]]);
            dead_left  = (dead_left > w) ? dead_left - w : '0;
            // zero width still holds the slot for a fixed time
            ticks_left = (w != 0) ? w : msps_pkg::EMPTY_SLOT_TICKS;
        end else begin
            // dead time used up: the dead slot falls back to a fixed length
            ticks_left = (dead_left != 0) ? dead_left[15:0] : msps_pkg::EMPTY_SLOT_TICKS;
        end
    endtask

    // one item through the sequencer shadow, giving the result it causes
    task automatic sequence_step(input logic op, input logic [msps_pkg::CH_IN_W-1:0] ch,
                                 input msps_pkg::t_ticks w, output t_slot_report rep);
        logic [3:0]       first;
        msps_pkg::t_ticks fw;
        // the width write lands before anything else
        if (op == msps_pkg::OP_WIDTH) begin
            width_store[ch] = limit_width(w);
        end
        if (en_mask == 0) begin
            // empty mask stops the sequencer
            seq_on     = 1'b0;
            cur_slot   = '0;
            ticks_left = '0;
        end else if (!seq_on) begin
            // start-up is not a tick; dead time starts at frame minus first width
            first      = next_enabled(0);
            fw         = limit_width(width_store[first[2:0]]);
            seq_on     = 1'b1;
            cur_slot   = first;
            dead_left  = (frame_len > fw) ? {1'b0, frame_len - fw} : '0;
            ticks_left = (fw != 0) ? fw : msps_pkg::EMPTY_SLOT_TICKS;
        end else if (op == msps_pkg::OP_TICK) begin
            if (ticks_left > 1) begin
                ticks_left = ticks_left - 1'b1;
            end else if (cur_slot >= DEAD_SLOT) begin
                // new frame
                dead_left = {1'b0, frame_len};
                enter_slot(next_enabled(0));
            end else begin
                enter_slot(next_enabled(cur_slot + 1));
            end
        end
        rep.lines = '0;
        if (seq_on && cur_slot < N_CH && limit_width(width_store[cur_slot[2:0]]) != 0) begin
            rep.lines = 8'd1 << cur_slot;
        end
        rep.slot = seq_on ? cur_slot : 4'd0;
        rep.run  = seq_on;
    endtask

    // register write; only called while the block is idle
    task automatic write_reg(input logic [msps_pkg::CFG_IDX_W-1:0] idx,
                             input msps_pkg::t_ticks data);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        case (idx)
            msps_pkg::REG_ENABLE_MASK: en_mask   = data[msps_pkg::MASK_W-1:0];
            msps_pkg::REG_MIN_PULSE:   lo_width  = data;
            msps_pkg::REG_MAX_PULSE:   hi_width  = data;
            msps_pkg::REG_FRAME:       frame_len = data;
            default: ;
        endcase
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // drop valid, let every owed result come back, then wait out the drain time
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (slot_reports_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // offer one item, hold it until the transfer, then log what it should cause
    task automatic send_item(input logic op, input logic [msps_pkg::CH_IN_W-1:0] ch,
                             input msps_pkg::t_ticks w, input logic typed,
                             input t_slot_report want);
        t_slot_report rep;
        int unsigned  gap;
        // idling regime follows the item count
        if (items_sent < IDLE_SPLIT) begin
            send_idle_pct = 37;
            recv_idle_pct = 57;
        end else if (items_sent < 2 * IDLE_SPLIT) begin
            send_idle_pct = 57;
            recv_idle_pct = 37;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge i_clk);
        end
        i_opcode      = op;
        i_channel     = ch;
        i_width_ticks = w;
        i_in_valid    = 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sequence_step(op, ch, w, rep);
        slot_reports_q.push_back(typed ? want : rep);
        items_sent++;
        @(negedge i_clk);
    endtask

    // random item: a width write with write_pct chance, else a tick; widths sometimes tiny and sometimes full range
    task automatic send_random(input int unsigned write_pct);
        logic             op;
        msps_pkg::t_ticks w;
        op = ($urandom_range(0, 99) < write_pct) ? msps_pkg::OP_WIDTH : msps_pkg::OP_TICK;
        w  = $urandom_range(0, 1) ? msps_pkg::t_ticks'($urandom_range(0, 16))
                                  : msps_pkg::t_ticks'($urandom());
        send_item(op, msps_pkg::CH_IN_W'($urandom_range(0, 7)), w, 1'b0, NO_REPORT);
    endtask

    // one configuration setting followed by a run of random items
    task automatic run_phase(input logic [msps_pkg::MASK_W-1:0] mask,
                             input msps_pkg::t_ticks lo, input msps_pkg::t_ticks hi,
                             input msps_pkg::t_ticks frame,
                             input int unsigned n, input int unsigned write_pct,
                             input logic halt_first);
        wait_idle();
        if (halt_first) begin
            // stop the sequencer so a long slot from before is not carried over
            write_reg(msps_pkg::REG_ENABLE_MASK, '0);
            send_item(msps_pkg::OP_TICK, 3'd0, '0, 1'b1, STOPPED);
            wait_idle();
        end
        write_reg(msps_pkg::REG_MIN_PULSE, lo);
        write_reg(msps_pkg::REG_MAX_PULSE, hi);
        write_reg(msps_pkg::REG_FRAME, frame);
        write_reg(msps_pkg::REG_ENABLE_MASK, {8'h00, mask});
        repeat (n) send_random(write_pct);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit, far beyond the slowest passing run
    initial begin
        #5_000_000;
        $display("multiplexed_servo_pulse_sequencer_tb: FAIL");
        $finish;
    end

    // receiver: random stalls, plus one long hold so the block backs up
    initial begin : receiver
        int unsigned hold_left;
        bit          pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        i_out_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (!pressure_done && items_sent >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                hold_left     = HOLD_CYCLES - 1;
                i_out_stall   = 1'b1;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // result check: every transfer against the oldest owed result
    always @(posedge i_clk) begin : check_results
        t_slot_report want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (slot_reports_q.size() == 0) begin
                fail_count++;
                if (fail_count <= PRINT_CAP) begin
                    $display("%0t: result with none owed: lines %h slot %0d running %b",
                             $time, o_pulse_lines, o_active_slot, o_running);
                end
            end else begin
                want = slot_reports_q.pop_front();
                results_checked++;
                if (o_pulse_lines !== want.lines || o_active_slot !== want.slot ||
                    o_running !== want.run) begin
                    fail_count++;
                    if (fail_count <= PRINT_CAP) begin
                        $display("%0t: mismatch lines exp %h got %h, slot exp %0d got %0d,",
                                 $time, want.lines, o_pulse_lines, want.slot,
                                 o_active_slot);
                        $display("    running exp %b got %b", want.run, o_running);
                    end
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        t_stim_row   plan [$];
        t_stim_row   row;
        logic [7:0]  mask;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_opcode        = msps_pkg::OP_TICK;
        i_channel       = '0;
        i_width_ticks   = '0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = msps_pkg::REG_ENABLE_MASK;
        i_cfg_data      = '0;
        items_sent      = 0;
        results_checked = 0;
        reg_writes      = 0;
        fail_count      = 0;
        send_idle_pct   = 37;
        recv_idle_pct   = 57;

        // shadow after reset
        foreach (width_store[c]) width_store[c] = '0;
        cur_slot   = '0;
        ticks_left = '0;
        dead_left  = {1'b0, msps_pkg::FRAME_RESET};
        seq_on     = 1'b0;
        en_mask    = '0;
        lo_width   = msps_pkg::MIN_RESET;
        hi_width   = msps_pkg::MAX_RESET;
        frame_len  = msps_pkg::FRAME_RESET;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: reset limits, start, walk, stop, max below min
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd0, 16'h0000, 1'b1, STOPPED));
        plan.push_back(item_row(msps_pkg::OP_WIDTH, 3'd0, 16'hFFFF, 1'b1, STOPPED));
        plan.push_back(item_row(msps_pkg::OP_WIDTH, 3'd7, 16'h0000, 1'b1, STOPPED));
        plan.push_back(item_row(msps_pkg::OP_WIDTH, 3'd3, 16'd1500, 1'b1, STOPPED));
        plan.push_back(cfg_row(msps_pkg::REG_MIN_PULSE,   16'd1));
        plan.push_back(cfg_row(msps_pkg::REG_MAX_PULSE,   16'd5));
        plan.push_back(cfg_row(msps_pkg::REG_FRAME,       16'd20));
        plan.push_back(cfg_row(msps_pkg::REG_ENABLE_MASK, 16'h00FF));
        // start on channel 0, stored 2000 clamped on use to 5
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd0, 16'h0000, 1'b1,
                                '{8'h01, 4'd0, 1'b1}));
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd7, 16'hFFFF, 1'b0, NO_REPORT));
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd1, 16'h5A5A, 1'b0, NO_REPORT));
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd2, 16'hA5A5, 1'b0, NO_REPORT));
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd4, 16'h0001, 1'b0, NO_REPORT));
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd6, 16'h8000, 1'b0, NO_REPORT));
        // width write mid-frame is not a tick
        plan.push_back(item_row(msps_pkg::OP_WIDTH, 3'd5, 16'd3,    1'b0, NO_REPORT));
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd0, 16'h0000, 1'b0, NO_REPORT));
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd0, 16'h0000, 1'b0, NO_REPORT));
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd0, 16'h0000, 1'b0, NO_REPORT));
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd0, 16'h0000, 1'b0, NO_REPORT));
        // empty mask stops and clears the lines
        plan.push_back(cfg_row(msps_pkg::REG_ENABLE_MASK, 16'h0000));
        plan.push_back(item_row(msps_pkg::OP_TICK,  3'd0, 16'h0000, 1'b1, STOPPED));
        // only the top channel, maximum below minimum
        plan.push_back(cfg_row(msps_pkg::REG_ENABLE_MASK, 16'h0080));
        plan.push_back(cfg_row(msps_pkg::REG_MIN_PULSE,   16'd7));
        plan.push_back(cfg_row(msps_pkg::REG_MAX_PULSE,   16'd3));
        // write lands first, then the start picks it up clamped to 3
        plan.push_back(item_row(msps_pkg::OP_WIDTH, 3'd7, 16'hFFFF, 1'b1,
                                '{8'h80, 4'd7, 1'b1}));
        repeat (4) begin
            plan.push_back(item_row(msps_pkg::OP_TICK, 3'd0, 16'h0000, 1'b0, NO_REPORT));
        end

        foreach (plan[r]) begin
            row = plan[r];
            if (row.kind == ROW_CFG) begin
                wait_idle();
                write_reg(row.reg_idx, row.val);
            end else begin
                send_item(row.op, row.ch, row.val, row.typed, row.want);
            end
        end
        directed_items = items_sent;

        // all channels, short frame that still leaves dead time
        run_phase(8'hFF, 16'd1, 16'd6, 16'd60, 80, 20, 1'b0);

        // random small settings, carried over from phase to phase
        repeat (6) begin
            mask = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            run_phase(mask, msps_pkg::t_ticks'($urandom_range(1, 6)),
                      msps_pkg::t_ticks'($urandom_range(1, 12)),
                      msps_pkg::t_ticks'($urandom_range(100, 150)), 40, 20, 1'b0);
        end

        // maximum below minimum: every width becomes the maximum
        run_phase(8'h25, 16'd9, 16'd3, 16'd10, 60, 25, 1'b0);

        // widest limits and longest frame
        run_phase(8'h80, 16'd0, 16'hFFFF, 16'hFFFF, 40, 50, 1'b1);

        // zero-width channel followed by a dead slot with no time left
        run_phase(8'h03, 16'd0, 16'd1, 16'd1, 0, 0, 1'b1);
        send_item(msps_pkg::OP_WIDTH, 3'd0, 16'hFFFF, 1'b0, NO_REPORT);
        send_item(msps_pkg::OP_WIDTH, 3'd1, 16'h0000, 1'b0, NO_REPORT);
        repeat (1020) begin
            send_item(msps_pkg::OP_TICK, msps_pkg::CH_IN_W'($urandom_range(0, 7)),
                      msps_pkg::t_ticks'($urandom()), 1'b0, NO_REPORT);
        end

        // drain and watch for stray results
        i_in_valid = 1'b0;
        while (slot_reports_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        $display("run: %0d items (%0d directed), %0d results checked, %0d failures",
                 items_sent, directed_items, results_checked, fail_count);
        $display("run: %0d register writes, stop/start, clamp order, zero width, no dead time",
                 reg_writes);
        if (fail_count == 0) begin
            $display("multiplexed_servo_pulse_sequencer_tb: PASS");
        end else begin
            $display("multiplexed_servo_pulse_sequencer_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/msps_pkg.sv
rtl/msps_ctrl.sv
rtl/msps_dp.sv
rtl/multiplexed_servo_pulse_sequencer.sv
rtl/msps_chk.sv
dv/multiplexed_servo_pulse_sequencer_tb.sv
